@@ design/ssr_pkg.sv @@
// Shared types and constants for the scanline span and sprite renderer.
// No dependencies; used by ssr_line_store and scanline_span_sprite_renderer_top.
package ssr_pkg;

    localparam int LINE_WIDTH_DEF    = 160;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int TEXEL_DEPTH       = 4096;
    localparam int TEXEL_AW          = 12;
    localparam int COL_W             = 8;
    localparam int CNT_W             = 9;
    localparam int FUNC_W            = 3;
    localparam int IN_DATA_W         = 80;
    localparam int OUT_DATA_W        = 16;
    localparam int PIXEL_W           = 16;
    localparam int STRIDE_W          = 8;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 8'd16;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_FILL   = 3'd0,
        FUNC_SPAN   = 3'd1,
        FUNC_SPRITE = 3'd2,
        FUNC_LOAD   = 3'd3,
        FUNC_READ   = 3'd4
    } func_t;

    typedef struct packed {
        logic               we;
        logic [COL_W-1:0]   wcol;
        logic [PIXEL_W-1:0] wdata;
        logic [COL_W-1:0]   rcol;
    } line_req_t;

endpackage

@@ design/ssr_line_store.sv @@
// Scanline pixel memory: one write port, one registered read port.
// Per-entry valid bits make unwritten pixels read as zero after reset. Uses ssr_pkg.
module ssr_line_store #(
    parameter int LINE_WIDTH = ssr_pkg::LINE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ssr_pkg::line_req_t            req,
    output logic [ssr_pkg::PIXEL_W-1:0]   rdata
);

    localparam int IDX_W = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;

    logic [ssr_pkg::PIXEL_W-1:0] mem [LINE_WIDTH];
    logic [LINE_WIDTH-1:0]       valid_reg;
    logic                        rvalid_reg;
    logic [ssr_pkg::PIXEL_W-1:0] rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg <= valid_reg[req.rcol[IDX_W-1:0]];
            if (req.we)
            begin
                valid_reg[req.wcol[IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[req.rcol[IDX_W-1:0]];
        if (req.we)
        begin
            mem[req.wcol[IDX_W-1:0]] <= req.wdata;
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

@@ design/scanline_span_sprite_renderer_top.sv @@
// Top level of the scanline span and scaled sprite renderer: command FSM and texel store.
// Depends on ssr_pkg and ssr_line_store.
//
//  channel   direction  signals                                   payload
//  s_axis    in         s_axis_tvalid/tready/tdata/tuser          one command
//  m_axis    out        m_axis_tvalid/tready/tdata                pixel result
//  cfg       in         cfg_valid/cfg_ready/cfg_data              sprite_row_stride
//
// A fill, span or sprite row steps from accept through setup, a run over its clipped columns
// (LINE_WIDTH for a fill) at one column per cycle through the line store write port, drain and
// done. Load, read and unused commands go from setup straight to drain and done.
// Reset clears control state, the stride to 16 and every line pixel (valid bits).
// A held result in the output register does not block the next command until it must be replaced.
module scanline_span_sprite_renderer_top #(
    parameter int LINE_WIDTH    = ssr_pkg::LINE_WIDTH_DEF,
    parameter int FRACTION_BITS = ssr_pkg::FRACTION_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // x_start[8:0], span_width[16:9], color[32:17], sprite_row[39:33],
    // step_x[63:40], texel_address[75:64], zero[79:76]
    input  logic [ssr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // func[2:0]
    input  logic [ssr_pkg::FUNC_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // pixel[15:0]
    output logic [ssr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ssr_pkg::STRIDE_W-1:0]     cfg_data
);

    localparam int PW  = FRACTION_BITS + ssr_pkg::TEXEL_AW;
    localparam int AW  = ssr_pkg::TEXEL_AW;
    localparam int CW  = ssr_pkg::CNT_W;
    localparam logic signed [10:0] LW_S = 11'(LINE_WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t                        state_reg;
    ssr_pkg::func_t                func_reg;
    logic [8:0]                    xs_reg;
    logic [7:0]                    w_reg;
    logic [ssr_pkg::PIXEL_W-1:0]   color_reg;
    logic [6:0]                    row_reg;
    logic [23:0]                   step_reg;
    logic [AW-1:0]                 taddr_reg;
    logic [ssr_pkg::STRIDE_W-1:0]  stride_reg;
    logic [CW-1:0]                 col_reg;
    logic [CW-1:0]                 end_reg;
    logic [PW-1:0]                 pos_reg;
    logic [AW-1:0]                 base_reg;
    logic                          t_pend_reg;
    logic [ssr_pkg::COL_W-1:0]     t_col_reg;
    logic [ssr_pkg::PIXEL_W-1:0]   res_reg;
    logic                          m_valid_reg;
    logic [ssr_pkg::OUT_DATA_W-1:0] m_data_reg;

    logic [ssr_pkg::PIXEL_W-1:0]   tex_mem [ssr_pkg::TEXEL_DEPTH];
    logic [ssr_pkg::PIXEL_W-1:0]   tex_rdata_reg;
    logic                          tex_we;
    logic [AW-1:0]                 tex_raddr;

    logic signed [10:0]            xs_ext;
    logic signed [10:0]            sum_s;
    logic [CW-1:0]                 lo_c;
    logic [CW-1:0]                 hi_c;
    logic [8:0]                    skip_c;
    logic [32:0]                   skip_prod;
    logic [14:0]                   base_prod;
    logic                          in_range;
    logic                          col_live;
    logic                          is_paint;
    logic                          out_free;

    ssr_pkg::line_req_t            line_req;
    logic [ssr_pkg::PIXEL_W-1:0]   line_rdata;

    ssr_line_store #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_line (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (line_req),
        .rdata (line_rdata)
    );

    // Clip and setup arithmetic
    always_comb
    begin
        xs_ext    = {{2{xs_reg[8]}}, xs_reg};
        sum_s     = xs_ext + $signed({3'b000, w_reg});
        lo_c      = xs_reg[8] ? '0 : {1'b0, xs_reg[7:0]};
        if (sum_s < 0)
        begin
            hi_c = '0;
        end
        else if (sum_s > LW_S)
        begin
            hi_c = CW'(LINE_WIDTH);
        end
        else
        begin
            hi_c = sum_s[CW-1:0];
        end
        skip_c    = xs_reg[8] ? 9'(~xs_reg + 9'd1) : '0;
        skip_prod = 33'(skip_c) * 33'(step_reg);
        base_prod = 15'(row_reg) * 15'(stride_reg);
        in_range  = !xs_reg[8] && ({1'b0, xs_reg[7:0]} < CW'(LINE_WIDTH));
        col_live  = (state_reg == ST_RUN) && (col_reg < end_reg);
        is_paint  = (func_reg == ssr_pkg::FUNC_FILL) || (func_reg == ssr_pkg::FUNC_SPAN);
        out_free  = !m_valid_reg || m_axis_tready;
        tex_we    = (state_reg == ST_SETUP) && (func_reg == ssr_pkg::FUNC_LOAD);
        tex_raddr = base_reg + pos_reg[PW-1:FRACTION_BITS];
    end

    // Line store port: paint writes from the column counter, sprite writes from the texel stage
    always_comb
    begin
        line_req.rcol = xs_reg[ssr_pkg::COL_W-1:0];
        if (t_pend_reg)
        begin
            line_req.we    = (tex_rdata_reg != '0);
            line_req.wcol  = t_col_reg;
            line_req.wdata = tex_rdata_reg;
        end
        else
        begin
            line_req.we    = col_live && is_paint;
            line_req.wcol  = col_reg[ssr_pkg::COL_W-1:0];
            line_req.wdata = color_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        tex_rdata_reg <= tex_mem[tex_raddr];
        if (tex_we)
        begin
            tex_mem[taddr_reg] <= color_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            stride_reg  <= ssr_pkg::STRIDE_RESET;
            t_pend_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            func_reg    <= ssr_pkg::FUNC_FILL;
            col_reg     <= '0;
            end_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                stride_reg <= cfg_data;
            end
            if (m_valid_reg && m_axis_tready && (state_reg != ST_DONE))
            begin
                m_valid_reg <= 1'b0;
            end
            t_pend_reg <= col_live && (func_reg == ssr_pkg::FUNC_SPRITE);
            t_col_reg  <= col_reg[ssr_pkg::COL_W-1:0];

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        func_reg  <= ssr_pkg::func_t'(s_axis_tuser);
                        xs_reg    <= s_axis_tdata[8:0];
                        w_reg     <= s_axis_tdata[16:9];
                        color_reg <= s_axis_tdata[32:17];
                        row_reg   <= s_axis_tdata[39:33];
                        step_reg  <= s_axis_tdata[63:40];
                        taddr_reg <= s_axis_tdata[75:64];
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP:
                begin
                    pos_reg  <= skip_prod[PW-1:0];
                    base_reg <= base_prod[AW-1:0];
                    unique case (func_reg)
                        ssr_pkg::FUNC_FILL:
                        begin
                            col_reg   <= '0;
                            end_reg   <= CW'(LINE_WIDTH);
                            state_reg <= ST_RUN;
                        end
                        ssr_pkg::FUNC_SPAN, ssr_pkg::FUNC_SPRITE:
                        begin
                            col_reg   <= lo_c;
                            end_reg   <= hi_c;
                            state_reg <= ST_RUN;
                        end
                        default:
                        begin
                            state_reg <= ST_DRAIN;
                        end
                    endcase
                end
                ST_RUN:
                begin
                    if (col_live)
                    begin
                        col_reg <= col_reg + CW'(1);
                        pos_reg <= pos_reg + PW'(step_reg);
                    end
                    else
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    res_reg   <= (func_reg == ssr_pkg::FUNC_READ && in_range) ? line_rdata : '0;
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign cfg_ready     = 1'b1;

`ifndef NO_ASSERTIONS
    a_line_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        line_req.we |-> (32'(line_req.wcol) < LINE_WIDTH))
        else $error("line store write beyond line width");

    a_texel_stage_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        t_pend_reg |-> (state_reg == ST_RUN || state_reg == ST_DRAIN))
        else $error("texel write-back pending outside run or drain");

    a_done_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("result not presented when output register was free");
`endif

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for scanline_span_sprite_renderer_top: drives command streams and
// stride writes, predicts pixel results (from a local line and texel model, or from the
// directed table) and compares. Depends on ssr_pkg and the renderer RTL.
module tb;

    localparam int LINE_W        = ssr_pkg::LINE_WIDTH_DEF;
    localparam int FRAC_BITS     = ssr_pkg::FRACTION_BITS_DEF;
    localparam int SETTLE_CYCLES = 200;
    localparam int STALL_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 450;

    localparam logic [ssr_pkg::FUNC_W-1:0] FUNC_RSVD5 = 3'd5;
    localparam logic [ssr_pkg::FUNC_W-1:0] FUNC_RSVD6 = 3'd6;
    localparam logic [ssr_pkg::FUNC_W-1:0] FUNC_RSVD7 = 3'd7;

    typedef struct packed {
        logic [ssr_pkg::FUNC_W-1:0]   func;
        logic signed [8:0]            x_start;
        logic [7:0]                   span_width;
        logic [ssr_pkg::PIXEL_W-1:0]  color;
        logic [6:0]                   sprite_row;
        logic [23:0]                  step_x;
        logic [ssr_pkg::TEXEL_AW-1:0] texel_address;
    } ssr_cmd_t;

    typedef struct packed {
        ssr_cmd_t                    cmd;
        logic                        typed;
        logic [ssr_pkg::PIXEL_W-1:0] px;
    } dir_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [ssr_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [ssr_pkg::FUNC_W-1:0]     s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [ssr_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [ssr_pkg::STRIDE_W-1:0]   cfg_data = '0;

    logic [ssr_pkg::PIXEL_W-1:0]  line_px [LINE_W];
    logic [ssr_pkg::PIXEL_W-1:0]  texels [ssr_pkg::TEXEL_DEPTH];
    bit                           texel_loaded [ssr_pkg::TEXEL_DEPTH];
    logic [ssr_pkg::STRIDE_W-1:0] row_stride = ssr_pkg::STRIDE_RESET;

    logic [ssr_pkg::PIXEL_W-1:0] pending_pixels [$];
    int                          mismatches = 0;
    int                          tx_idle_pct = 0;
    int                          rx_idle_pct = 0;
    bit                          rx_hold_req = 1'b0;
    int                          stall_cycles = 0;
    int                          items_sent = 0;

    dir_row_t dir_rows [25];

    scanline_span_sprite_renderer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void clip_cols(input ssr_cmd_t c, output int lo, output int hi);
        int xs;
        int w;
        xs = int'(c.x_start);
        w  = int'(c.span_width);
        lo = (xs < 0) ? 0 : xs;
        hi = (xs + w > LINE_W) ? LINE_W : xs + w;
    endfunction

    function automatic logic [ssr_pkg::TEXEL_AW-1:0] sprite_texel(ssr_cmd_t c, int col);
        logic [31:0] offset;
        logic [31:0] base;
        logic [31:0] pos;
        logic [31:0] sum;
        offset = 32'(col - int'(c.x_start));
        base   = 32'(c.sprite_row) * 32'(row_stride);
        pos    = offset * 32'(c.step_x);
        sum    = base + (pos >> FRAC_BITS);
        return sum[ssr_pkg::TEXEL_AW-1:0];
    endfunction

    function automatic logic [ssr_pkg::PIXEL_W-1:0] render_cmd(ssr_cmd_t c);
        int                          lo;
        int                          hi;
        int                          xs;
        logic [ssr_pkg::PIXEL_W-1:0] t;
        logic [ssr_pkg::PIXEL_W-1:0] px;
        px = '0;
        xs = int'(c.x_start);
        case (c.func)
            ssr_pkg::FUNC_FILL:
                for (int col = 0; col < LINE_W; col++) line_px[col] = c.color;
            ssr_pkg::FUNC_SPAN:
            begin
                clip_cols(c, lo, hi);
                for (int col = lo; col < hi; col++) line_px[col] = c.color;
            end
            ssr_pkg::FUNC_SPRITE:
            begin
                clip_cols(c, lo, hi);
                for (int col = lo; col < hi; col++)
                begin
                    t = texels[sprite_texel(c, col)];
                    if (t != '0) line_px[col] = t;
                end
            end
            ssr_pkg::FUNC_LOAD:
            begin
                texels[c.texel_address]       = c.color;
                texel_loaded[c.texel_address] = 1'b1;
            end
            ssr_pkg::FUNC_READ:
                if (xs >= 0 && xs < LINE_W) px = line_px[xs];
            default:
                ;
        endcase
        return px;
    endfunction

    function automatic logic signed [8:0] rand_col();
        int v;
        if ($urandom_range(0, 9) < 7)
            v = int'($urandom_range(0, 190)) - 20;
        else
            v = int'($urandom_range(0, 511));
        return v[8:0];
    endfunction

    function automatic logic [7:0] rand_width();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1, 2:    return 8'($urandom_range(0, 255));
            3:       return 8'($urandom_range(200, 255));
            default: return 8'($urandom_range(1, 40));
        endcase
    endfunction

    function automatic ssr_cmd_t gen_cmd();
        ssr_cmd_t c;
        int       pick;
        c.x_start       = rand_col();
        c.span_width    = rand_width();
        c.color         = 16'($urandom_range(0, 65535));
        c.sprite_row    = 7'($urandom_range(0, 127));
        c.step_x        = 24'($urandom_range(0, 24'hFFFFFF));
        c.texel_address = 12'($urandom_range(0, ssr_pkg::TEXEL_DEPTH - 1));
        pick = $urandom_range(0, 99);
        if (pick < 6)
            c.func = ssr_pkg::FUNC_FILL;
        else if (pick < 30)
            c.func = ssr_pkg::FUNC_SPAN;
        else if (pick < 58)
        begin
            c.func = ssr_pkg::FUNC_SPRITE;
            case ($urandom_range(0, 9))
                0:       c.step_x = '0;
                1, 2:    c.step_x = 24'h010000;
                3, 4:    c.step_x = 24'($urandom_range(0, 16'hFFFF));
                5:       ;
                default: c.step_x = 24'($urandom_range(24'h004000, 24'h020000));
            endcase
        end
        else if (pick < 68)
        begin
            c.func = ssr_pkg::FUNC_LOAD;
            if ($urandom_range(0, 3) == 0) c.color = '0;
        end
        else if (pick < 95)
        begin
            c.func = ssr_pkg::FUNC_READ;
            if ($urandom_range(0, 9) < 8) c.x_start = 9'($urandom_range(0, LINE_W - 1));
        end
        else
            c.func = 3'($urandom_range(FUNC_RSVD5, FUNC_RSVD7));
        return c;
    endfunction

    task automatic report_mismatch(string what, logic [ssr_pkg::PIXEL_W-1:0] got,
                                   logic [ssr_pkg::PIXEL_W-1:0] want);
        $display("mismatch (%s): pixel %h, expected %h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    task automatic send_one(ssr_cmd_t c, logic typed, logic [ssr_pkg::PIXEL_W-1:0] typed_px);
        logic [ssr_pkg::PIXEL_W-1:0] px;
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.func;
        s_axis_tdata  <= {4'b0, c.texel_address, c.step_x, c.sprite_row, c.color,
                          c.span_width, c.x_start};
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
        px = render_cmd(c);
        pending_pixels.push_back(typed ? typed_px : px);
    endtask

    // load every texel a sprite row will touch before the row itself
    task automatic issue_cmd(ssr_cmd_t c, logic typed, logic [ssr_pkg::PIXEL_W-1:0] typed_px);
        int                           lo;
        int                           hi;
        logic [ssr_pkg::TEXEL_AW-1:0] a;
        ssr_cmd_t                     ld;
        if (c.func == ssr_pkg::FUNC_SPRITE)
        begin
            clip_cols(c, lo, hi);
            for (int col = lo; col < hi; col++)
            begin
                a = sprite_texel(c, col);
                if (!texel_loaded[a])
                begin
                    ld               = gen_cmd();
                    ld.func          = ssr_pkg::FUNC_LOAD;
                    ld.texel_address = a;
                    if ($urandom_range(0, 3) == 0) ld.color = '0;
                    send_one(ld, 1'b1, '0);
                end
            end
        end
        send_one(c, typed, typed_px);
    endtask

    task automatic hold_sender();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain_pixels();
        hold_sender();
        while (pending_pixels.size() != 0) @(posedge clk);
    endtask

    task automatic write_stride(logic [ssr_pkg::STRIDE_W-1:0] v);
        drain_pixels();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        row_stride = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                rx_hold_req = 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        logic [ssr_pkg::PIXEL_W-1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_pixels.size() == 0)
                report_mismatch("no pixel pending", m_axis_tdata, '0);
            else
            begin
                want = pending_pixels.pop_front();
                if (m_axis_tdata !== want) report_mismatch("pixel", m_axis_tdata, want);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [ssr_pkg::STRIDE_W-1:0] strides [4];
        int                           phase_start;
        bit                           mid_done;
        for (int col = 0; col < LINE_W; col++) line_px[col] = '0;
        strides[0] = 8'd1;
        strides[1] = 8'd255;
        strides[2] = 8'd0;
        strides[3] = 8'($urandom_range(2, 254));

        // func, x_start, span_width, color, sprite_row, step_x, texel_address; typed, pixel
        dir_rows = '{
            '{'{ssr_pkg::FUNC_READ, 9'sd0, 8'd0, 16'h0000, 7'd0, 24'h0, 12'd0},
              1'b1, 16'h0000},
            '{'{ssr_pkg::FUNC_READ, 9'sd159, 8'd0, 16'h0000, 7'd0, 24'h0, 12'd0},
              1'b1, 16'h0000},
            '{'{ssr_pkg::FUNC_FILL, 9'sd0, 8'd0, 16'hFFFF, 7'd0, 24'h0, 12'd0},
              1'b1, 16'h0000},
            '{'{ssr_pkg::FUNC_READ, 9'sd0, 8'd0, 16'h0000, 7'd0, 24'h0, 12'd0},
              1'b1, 16'hFFFF},
            '{'{ssr_pkg::FUNC_READ, 9'sd159, 8'd0, 16'h0000, 7'd0, 24'h0, 12'd0},
              1'b1, 16'hFFFF},
            '{'{ssr_pkg::FUNC_READ, 9'sd160, 8'd0, 16'h0000, 7'd0, 24'h0, 12'd0},
              1'b1, 16'h0000},
            '{'{ssr_pkg::FUNC_READ, -9'sd1, 8'd0, 16'h0000, 7'd0, 24'h0, 12'd0},
              1'b1, 16'h0000},
            '{'{ssr_pkg::FUNC_SPAN, -9'sd256, 8'd255, 16'h1234, 7'd0, 24'h0, 12'd0},
              1'b1, 16'h0000},
            '{'{ssr_pkg::FUNC_SPAN, -9'sd5, 8'd10, 16'hA5A5, 7'd0, 24'h0, 12'd0},
              1'b1, 16'h0000},
            '{'{ssr_pkg::FUNC_READ, 9'sd4, 8'd0, 16'h0000, 7'd0, 24'h0, 12'd0},
              1'b0, 16'h0000},
            '{'{ssr_pkg::FUNC_READ, 9'sd5, 8'd0, 16'h0000, 7'd0, 24'h0, 12'd0},
              1'b0, 16'h0000},
            '{'{ssr_pkg::FUNC_SPAN, 9'sd150, 8'd255, 16'h5A5A, 7'd0, 24'h0, 12'd0},
              1'b1, 16'h0000},
            '{'{ssr_pkg::FUNC_SPAN, 9'sd255, 8'd255, 16'h0F0F, 7'd0, 24'h0, 12'd0},
              1'b1, 16'h0000},
            '{'{ssr_pkg::FUNC_READ, 9'sd159, 8'd0, 16'h0000, 7'd0, 24'h0, 12'd0},
              1'b0, 16'h0000},
            '{'{ssr_pkg::FUNC_SPAN, 9'sd10, 8'd0, 16'h0000, 7'd0, 24'h0, 12'd0},
              1'b1, 16'h0000},
            '{'{ssr_pkg::FUNC_LOAD, 9'sd0, 8'd0, 16'h0001, 7'd0, 24'h0, 12'd0},
              1'b1, 16'h0000},
            '{'{ssr_pkg::FUNC_LOAD, 9'sd0, 8'd0, 16'hFFFF, 7'd0, 24'h0, 12'd4095},
              1'b1, 16'h0000},
            '{'{ssr_pkg::FUNC_LOAD, 9'sd0, 8'd0, 16'h0000, 7'd0, 24'h0, 12'd16},
              1'b1, 16'h0000},
            '{'{ssr_pkg::FUNC_SPRITE, -9'sd3, 8'd8, 16'h0000, 7'd0, 24'h010000, 12'd0},
              1'b1, 16'h0000},
            '{'{ssr_pkg::FUNC_SPRITE, 9'sd155, 8'd255, 16'h0000, 7'd127, 24'hFFFFFF, 12'd0},
              1'b1, 16'h0000},
            '{'{ssr_pkg::FUNC_SPRITE, 9'sd20, 8'd30, 16'h0000, 7'd1, 24'h0, 12'd0},
              1'b1, 16'h0000},
            '{'{ssr_pkg::FUNC_READ, 9'sd0, 8'd0, 16'h0000, 7'd0, 24'h0, 12'd0},
              1'b0, 16'h0000},
            '{'{FUNC_RSVD5, 9'sd0, 8'd255, 16'hFFFF, 7'd0, 24'h0, 12'd0},
              1'b1, 16'h0000},
            '{'{FUNC_RSVD6, 9'sd0, 8'd255, 16'hFFFF, 7'd0, 24'h0, 12'd0},
              1'b1, 16'h0000},
            '{'{FUNC_RSVD7, 9'sd20, 8'd0, 16'h0000, 7'd0, 24'h0, 12'd0},
              1'b0, 16'h0000}
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 11;
        rx_idle_pct = 45;
        foreach (dir_rows[i]) issue_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].px);

        for (int p = 0; p < 4; p++)
        begin
            write_stride(strides[p]);
            tx_idle_pct = (p == 0) ? 11 : (p == 1) ? 45 : 0;
            rx_idle_pct = (p == 0) ? 45 : (p == 1) ? 11 : 0;
            phase_start = items_sent;
            mid_done    = 1'b0;
            for (int i = 0; items_sent - phase_start < PHASE_ITEMS; i++)
            begin
                // stall the result side long enough to back up the command side
                if (p == 0 && i == 40) rx_hold_req = 1'b1;
                if (!mid_done && (items_sent - phase_start >= PHASE_ITEMS / 2))
                begin
                    drain_pixels();
                    mid_done = 1'b1;
                end
                issue_cmd(gen_cmd(), 1'b0, '0);
            end
        end

        drain_pixels();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
design/ssr_pkg.sv
design/ssr_line_store.sv
design/scanline_span_sprite_renderer_top.sv
dv/tb.sv
